>>> hw/rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

	localparam int unsigned OPERAND_BITS_DEF = 31;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ISSUE,
		S_WAIT,
		S_FINISH
	} mexp_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mexp_modmul.sv
`default_nettype none

// Modular multiplier: one registered multiply, then a restoring remainder
// that takes one product bit per cycle, most significant bit first.
module mexp_modmul import mexp_pkg::*; #(
	parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [OPERAND_BITS-1:0] a,
	input  wire logic [OPERAND_BITS-1:0] b,
	input  wire logic [OPERAND_BITS-1:0] m,
	output logic                         done,
	output logic [OPERAND_BITS-1:0]      res
);

	localparam int unsigned PW = 2 * OPERAND_BITS;
	localparam int unsigned CW = $clog2(PW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     prod_q;
	logic [OPERAND_BITS-1:0] rem_q;

	logic [OPERAND_BITS:0]   shifted;
	logic [OPERAND_BITS:0]   diff;
	logic [OPERAND_BITS-1:0] rem_next;
	logic                    last;

	always_comb begin
		shifted  = {rem_q, prod_q[PW-1]};
		diff     = shifted - {1'b0, m};
		rem_next = (shifted >= {1'b0, m}) ? diff[OPERAND_BITS-1:0]
		                                  : shifted[OPERAND_BITS-1:0];
		last     = busy_q && (cnt_q == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PW'(a) * PW'(b);
			rem_q  <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[PW-2:0], 1'b0};
			rem_q  <= rem_next;
		end
	end

	assign done = done_q;
	assign res  = rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/modular_exponentiation_unit.sv
`default_nettype none

// Computes base^exponent mod modulus by left-to-right square-and-multiply,
// one item at a time. A zero modulus returns 0 with bad_modulus set, a zero
// exponent returns 1 mod modulus, and an exponent of one returns the base
// unreduced; these resolve at acceptance and the result is offered next
// cycle. Otherwise the block scans down to the top set exponent bit (one
// bit per cycle from the top of the word), then for every lower bit runs a
// modular square and, when that bit is set, a modular multiply by the base.
// Each such operation runs in the shared multiply-and-remainder unit, whose
// bit-serial remainder sets the pace. The input is stalled while an item is
// in progress or a result waits unread.
module modular_exponentiation_unit import mexp_pkg::*; #(
	parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [OPERAND_BITS-1:0] base,
	input  wire logic [OPERAND_BITS-1:0] exponent,
	input  wire logic [OPERAND_BITS-1:0] modulus,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [OPERAND_BITS-1:0]      power_result,
	output logic                         bad_modulus
);

	localparam int unsigned BW = $clog2(OPERAND_BITS + 1);

	mexp_state_t state_q, state_d;

	logic [OPERAND_BITS-1:0] base_q;
	logic [OPERAND_BITS-1:0] mod_q;
	logic [OPERAND_BITS-1:0] e_q;
	logic [OPERAND_BITS-1:0] acc_q;
	logic [BW-1:0]           bits_q;
	logic                    mul_ph_q;
	logic                    out_valid_q;
	logic [OPERAND_BITS-1:0] power_q;
	logic                    bad_q;

	logic                    accept;
	logic                    out_free;
	logic                    quick;
	logic [OPERAND_BITS-1:0] quick_val;
	logic                    mm_start;
	logic [OPERAND_BITS-1:0] mm_b;
	logic                    mm_done;
	logic [OPERAND_BITS-1:0] mm_res;
	logic                    more_mul;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign more_mul = !mul_ph_q && e_q[OPERAND_BITS-1];

	always_comb begin
		quick     = 1'b1;
		quick_val = '0;
		if (modulus == '0) begin
			quick_val = '0;
		end else if (exponent == '0) begin
			quick_val = (modulus == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
		end else if (exponent == OPERAND_BITS'(1)) begin
			quick_val = base;
		end else begin
			quick = 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		mm_start = 1'b0;
		mm_b     = mul_ph_q ? base_q : acc_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !quick) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (e_q[OPERAND_BITS-1]) begin
					state_d = (bits_q == BW'(1)) ? S_FINISH : S_ISSUE;
				end
			end
			S_ISSUE: begin
				mm_start = 1'b1;
				state_d  = S_WAIT;
			end
			S_WAIT: begin
				if (mm_done) begin
					if (more_mul || bits_q != BW'(1)) begin
						state_d = S_ISSUE;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mul_ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((accept && quick) || (state_q == S_FINISH && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				mul_ph_q <= 1'b0;
			end else if (state_q == S_WAIT && mm_done) begin
				mul_ph_q <= more_mul;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base;
			mod_q  <= modulus;
			e_q    <= exponent;
			bits_q <= BW'(OPERAND_BITS);
			if (quick) begin
				power_q <= quick_val;
				bad_q   <= (modulus == '0);
			end
		end else if (state_q == S_SCAN) begin
			// drop leading zeros; the top set bit seeds the accumulator
			e_q    <= {e_q[OPERAND_BITS-2:0], 1'b0};
			bits_q <= bits_q - BW'(1);
			if (e_q[OPERAND_BITS-1]) begin
				acc_q <= base_q;
			end
		end else if (state_q == S_WAIT && mm_done) begin
			acc_q <= mm_res;
			if (!more_mul) begin
				e_q    <= {e_q[OPERAND_BITS-2:0], 1'b0};
				bits_q <= bits_q - BW'(1);
			end
		end else if (state_q == S_FINISH && out_free) begin
			power_q <= acc_q;
			bad_q   <= 1'b0;
		end
	end

	mexp_modmul #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.a     (acc_q),
		.b     (mm_b),
		.m     (mod_q),
		.done  (mm_done),
		.res   (mm_res)
	);

	assign out_valid    = out_valid_q;
	assign power_result = power_q;
	assign bad_modulus  = bad_q;

`ifndef ASSERT_OFF
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_modulus |-> power_result == '0)
		else $error("bad_modulus result not zero");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> mm_res < mod_q)
		else $error("remainder not below modulus");

	a_busy_mod: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> mod_q != '0)
		else $error("loop running with zero modulus");
`endif

endmodule

`default_nettype wire

>>> sim/modular_exponentiation_unit_tb.sv
`timescale 1ns / 100ps

module modular_exponentiation_unit_tb;
	import mexp_pkg::*;

	localparam int unsigned W = OPERAND_BITS_DEF;
	localparam logic [W-1:0] TOP = '1;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TAIL_CYCLES = 300;
	localparam int RANDOM_ITEMS = 120;
	localparam int CALM_ITEMS = 20;

	typedef struct packed {
		logic [W-1:0] power_result;
		logic         bad_modulus;
	} power_t;

	// known set: the result is typed into the row, otherwise it is predicted
	typedef struct packed {
		logic [W-1:0] base;
		logic [W-1:0] exponent;
		logic [W-1:0] modulus;
		logic         known;
		logic [W-1:0] power_result;
		logic         bad_modulus;
	} power_case_t;

	localparam int N_DIRECTED = 20;
	localparam power_case_t DIRECTED_CASES [N_DIRECTED] = '{
		'{31'd5,          31'd3,          31'd0,          1'b1, 31'd0,   1'b1},
		'{TOP,            TOP,            31'd0,          1'b1, 31'd0,   1'b1},
		'{31'd5,          31'd1,          31'd0,          1'b1, 31'd0,   1'b1},
		'{31'd7,          31'd0,          31'd1,          1'b1, 31'd0,   1'b0},
		'{TOP,            31'd0,          TOP,            1'b1, 31'd1,   1'b0},
		'{31'd0,          31'd0,          31'd13,         1'b1, 31'd1,   1'b0},
		'{TOP,            31'd1,          31'd3,          1'b1, TOP,     1'b0},
		'{31'd0,          31'd1,          TOP,            1'b1, 31'd0,   1'b0},
		'{31'd100,        31'd1,          31'd7,          1'b1, 31'd100, 1'b0},
		'{31'd0,          TOP,            TOP,            1'b1, 31'd0,   1'b0},
		'{31'd1,          TOP,            TOP,            1'b1, 31'd1,   1'b0},
		'{TOP,            TOP,            TOP,            1'b0, 31'd0,   1'b0},
		'{TOP - 31'd1,    TOP,            TOP - 31'd1,    1'b0, 31'd0,   1'b0},
		'{31'd2,          31'd10,         31'd1000,       1'b0, 31'd0,   1'b0},
		'{31'd3,          31'd2,          31'd1,          1'b0, 31'd0,   1'b0},
		'{TOP,            31'd2,          31'd1000003,    1'b0, 31'd0,   1'b0},
		'{31'd12345,      31'h4000_0000,  31'd1000003,    1'b0, 31'd0,   1'b0},
		'{31'h2AAA_AAAA,  31'h5555_5555,  31'h7FFF_FFED,  1'b0, 31'd0,   1'b0},
		'{31'h5555_5555,  31'h2AAA_AAAA,  31'd2,          1'b0, 31'd0,   1'b0},
		'{TOP,            31'd3,          31'd2147483629, 1'b0, 31'd0,   1'b0}
	};

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_stall;
	logic [W-1:0] base;
	logic [W-1:0] exponent;
	logic [W-1:0] modulus;
	logic         out_valid;
	logic         out_stall = 1'b0;
	logic [W-1:0] power_result;
	logic         bad_modulus;

	power_t expected_powers [$];
	int     mismatches = 0;
	int     cycle_count = 0;
	int     stall_left = 0;
	bit     calm = 1'b0;

	modular_exponentiation_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.base         (base),
		.exponent     (exponent),
		.modulus      (modulus),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.power_result (power_result),
		.bad_modulus  (bad_modulus)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic power_t predict_power(input logic [W-1:0] b, e, m);
		power_t res;
		logic [63:0] acc;
		logic [63:0] bb;
		logic [63:0] mm;
		int top;
		int i;
		res.power_result = '0;
		res.bad_modulus = 1'b0;
		if (m == '0) begin
			res.bad_modulus = 1'b1;
			return res;
		end
		bb = 64'(b);
		mm = 64'(m);
		if (e == '0) begin
			acc = 64'd1 % mm;
		end else begin
			top = W - 1;
			while (top > 0 && !e[top])
				top--;
			// start from the base as given; only products get reduced
			acc = bb;
			for (i = top - 1; i >= 0; i--) begin
				acc = (acc * acc) % mm;
				if (e[i])
					acc = (acc * bb) % mm;
			end
		end
		res.power_result = acc[W-1:0];
		return res;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic offer_item(input logic [W-1:0] b, e, m, input logic known,
			input power_t typed);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		base <= b;
		exponent <= e;
		modulus <= m;
		do @(posedge clk); while (in_stall);
		if (known)
			expected_powers.push_back(typed);
		else
			expected_powers.push_back(predict_power(b, e, m));
	endtask

	// receiver stalls in random bursts, no new burst once the run has gone calm
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		power_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_powers.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %0d bad=%0b",
					power_result, bad_modulus));
			end else begin
				want = expected_powers.pop_front();
				if (power_result !== want.power_result)
					flag_mismatch($sformatf("power_result %0d, want %0d",
						power_result, want.power_result));
				if (bad_modulus !== want.bad_modulus)
					flag_mismatch($sformatf("bad_modulus %0b, want %0b",
						bad_modulus, want.bad_modulus));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		power_case_t row;
		power_t typed;
		logic [W-1:0] b;
		logic [W-1:0] e;
		logic [W-1:0] m;
		logic [31:0] span;
		int ew;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		base = '0;
		exponent = '0;
		modulus = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_CASES[k]) begin
			row = DIRECTED_CASES[k];
			typed.power_result = row.power_result;
			typed.bad_modulus = row.bad_modulus;
			offer_item(row.base, row.exponent, row.modulus, row.known, typed);
		end

		// hold off the sender until the block has drained
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_powers.size() != 0)
			@(posedge clk);

		typed = '0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				m = '0;
			else if (pick < 10)
				m = W'(1);
			else if (pick < 40)
				m = W'($urandom_range(2, 1000));
			else
				m = W'($urandom);
			b = ($urandom_range(0, 1) == 0) ? W'($urandom) : W'($urandom_range(0, 100));
			// keep most exponents to 12 bits or less, some longer up to full width
			ew = ($urandom_range(0, 4) == 0) ? $urandom_range(13, W) : $urandom_range(0, 12);
			if (ew == 0) begin
				e = '0;
			end else begin
				span = (32'd1 << ew) - 32'd1;
				e = W'(($urandom & span) | (32'd1 << (ew - 1)));
			end
			offer_item(b, e, m, 1'b0, typed);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (expected_powers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_modmul.sv
hw/rtl/modular_exponentiation_unit.sv
sim/modular_exponentiation_unit_tb.sv
